// ----- sv/assert_macros.svh -----
// Assertion macros shared by the table interpolation RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- sv/tif_pkg.sv -----
// Shared types and constants for the table interpolation engine.
// Used by every module of the block; depends on nothing.
package tif_pkg;

  localparam int COND_W        = 24;
  localparam int PULSE_W       = 15;
  localparam int POS_W         = 16;
  localparam int IDX_W         = 7;
  localparam int OP_W          = 2;
  localparam int LEVEL_W       = 7;
  localparam int MAX_LEVEL_DEF = 64;
  localparam int FRAC_BITS_DEF = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_INV  = 2'd2
  } tif_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_RD0,
    ST_FWD_RD1,
    ST_FWD_MUL,
    ST_FWD_ADD,
    ST_INV_PRIME,
    ST_INV_SCAN,
    ST_DIV_WAIT,
    ST_DONE
  } tif_state_e;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        entry_index;
    logic signed [POS_W-1:0] pulse_position;
    logic [COND_W-1:0]       conductance;
  } tif_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_result;
    logic [COND_W-1:0]  conductance_result;
    logic               status;
  } tif_result_t;

endpackage

// ----- sv/table_interp_forward_inverse_top.sv -----
// A load is written to the table in the cycle it is taken. A forward lookup passes through
// ST_FWD_RD0 and ST_FWD_RD1, then ST_FWD_MUL and ST_FWD_ADD when the position has a fraction.
// An inverse lookup scans the table RAM one entry per cycle through its single read port,
// then the divider yields one bit per cycle.
// One item is in work at a time; the next transfer is taken the cycle after a result enters
// the output register. Reset clears control state and sets max_level to 64; table undefined.
`include "assert_macros.svh"
module table_interp_forward_inverse_top import tif_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LEVEL_W-1:0] cfg_data_i,      // max_level
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [47:0]        s_axis_tdata_i,  // entry_index, pulse_position, conductance, pad
  input  logic [OP_W-1:0]    s_axis_tuser_i,  // operation
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o,  // pulse_result, conductance_result, pad
  output logic               m_axis_tuser_o   // status
);

  localparam int AW = $clog2(MAX_LEVEL + 1);

  logic [LEVEL_W-1:0]  max_level_q;
  logic [AW-1:0]       lvl;
  tif_item_t           item;
  tif_result_t         res, out_q;
  logic                res_valid, res_ready, out_valid_q;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [COND_W-1:0]   ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [COND_W-1:0]   div_num, div_den;
  logic [FRAC_BITS:0]  div_quot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= LEVEL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_level_q <= cfg_data_i;
    end
  end

  assign lvl = (32'(max_level_q) > MAX_LEVEL) ? AW'(MAX_LEVEL) : AW'(max_level_q);

  assign item.operation      = s_axis_tuser_i;
  assign item.entry_index    = s_axis_tdata_i[6:0];
  assign item.pulse_position = s_axis_tdata_i[22:7];
  assign item.conductance    = s_axis_tdata_i[46:23];

  tif_ram #(
    .WIDTH(COND_W),
    .DEPTH(MAX_LEVEL + 1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tif_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  tif_ctrl #(
    .MAX_LEVEL(MAX_LEVEL),
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lvl_i      (lvl),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .div_start_o(div_start),
    .div_num_o  (div_num),
    .div_den_o  (div_den),
    .div_done_i (div_done),
    .div_quot_i (div_quot)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.conductance_result, out_q.pulse_result};
  assign m_axis_tuser_o  = out_q.status;

  `TIF_ASSERT_IMPL(a_ready_not_done, clk_i, rst_ni, s_axis_tready_o, !res_valid)
  `TIF_ASSERT_IMPL(a_write_no_read, clk_i, rst_ni, ram_we, !ram_re && !div_start)
  `TIF_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, res_valid && res_ready, m_axis_tvalid_o)

endmodule

// ----- sv/tif_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on tif_pkg for default sizes only.
module tif_ram import tif_pkg::*; #(
  parameter int WIDTH = COND_W,
  parameter int DEPTH = MAX_LEVEL_DEF + 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tif_div.sv -----
// Restoring divider for the inverse fraction, one quotient bit per cycle.
// Computes (num << FRAC_BITS) / den for num <= den; depends on tif_pkg.
module tif_div import tif_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CNT_W    = $clog2(FRAC_BITS + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COND_W-1:0]  num_i,
  input  logic [COND_W-1:0]  den_i,
  output logic               done_o,
  output logic [FRAC_BITS:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COND_W:0]    rem_q, rem_d;
  logic [COND_W-1:0]  den_q, den_d;
  logic [FRAC_BITS:0] quot_q, quot_d;
  logic               bit_w;
  logic [COND_W:0]    rem_sub;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    bit_w   = rem_q >= {1'b0, den_q};
    rem_sub = bit_w ? rem_q - {1'b0, den_q} : rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(FRAC_BITS + 1);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the shift cannot overflow.
      rem_d  = {rem_sub[COND_W-1:0], 1'b0};
      quot_d = {quot_q[FRAC_BITS-1:0], bit_w};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/tif_ctrl.sv -----
// Sequencer and datapath for loads, forward lookups and inverse table scans.
// Drives the table RAM and the divider; depends on tif_pkg.
module tif_ctrl import tif_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int AW       = $clog2(MAX_LEVEL + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [AW-1:0]      lvl_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tif_item_t          item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output tif_result_t        res_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [COND_W-1:0]  ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [COND_W-1:0]  ram_rdata_i,
  output logic               div_start_o,
  output logic [COND_W-1:0]  div_num_o,
  output logic [COND_W-1:0]  div_den_o,
  input  logic               div_done_i,
  input  logic [FRAC_BITS:0] div_quot_i
);

  localparam int P_W    = (AW + FRAC_BITS > 15) ? AW + FRAC_BITS : 15;
  localparam int PS_W   = (AW + FRAC_BITS + 1 > PULSE_W) ? AW + FRAC_BITS + 1 : PULSE_W;
  localparam int PROD_W = COND_W + FRAC_BITS + 2;

  tif_state_e state_q, state_d;

  logic [AW-1:0]               x1_q, x1_d;
  logic [FRAC_BITS-1:0]        frac_q, frac_d;
  logic [COND_W-1:0]           target_q, target_d;
  logic [COND_W-1:0]           a_q, a_d;
  logic signed [PROD_W-1:0]    prod_q, prod_d;
  logic [AW-1:0]               j_q, j_d;
  logic [AW-1:0]               seg_q, seg_d;
  tif_result_t                 res_q, res_d;

  logic                        accept;
  tif_op_e                     op;
  logic [P_W-1:0]              top_p, pos_mag, p_clamp;
  logic                        bracket, last_seg;
  logic [COND_W-1:0]           lo_v, hi_v, num_v, den_v;
  logic [AW-1:0]               seg_v;
  logic [PS_W-1:0]             pulse_sum;
  logic signed [COND_W:0]      diff;
  logic signed [PROD_W-1:0]    val;

  assign accept = in_valid_i && in_ready_o;
  assign op     = tif_op_e'(item_i.operation);

  // Clamp the query position to 0..level before splitting it.
  always_comb begin
    top_p   = P_W'({lvl_i, {FRAC_BITS{1'b0}}});
    pos_mag = P_W'(item_i.pulse_position[POS_W-2:0]);
    if (item_i.pulse_position[POS_W-1]) begin
      p_clamp = '0;
    end else if (pos_mag > top_p) begin
      p_clamp = top_p;
    end else begin
      p_clamp = pos_mag;
    end
  end

  // Segment test between the previous entry and the one just read.
  always_comb begin
    lo_v     = (a_q < ram_rdata_i) ? a_q : ram_rdata_i;
    hi_v     = (a_q < ram_rdata_i) ? ram_rdata_i : a_q;
    bracket  = (j_q != '0) && (lo_v <= target_q) && (target_q <= hi_v);
    last_seg = (j_q == lvl_i);
    num_v    = (target_q >= a_q) ? target_q - a_q : a_q - target_q;
    den_v    = (ram_rdata_i >= a_q) ? ram_rdata_i - a_q : a_q - ram_rdata_i;
    seg_v    = j_q - 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_FWD:  state_d = ST_FWD_RD0;
            OP_INV:  state_d = ST_INV_PRIME;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FWD_RD0:   state_d = ST_FWD_RD1;
      ST_FWD_RD1:   state_d = (frac_q == '0) ? ST_DONE : ST_FWD_MUL;
      ST_FWD_MUL:   state_d = ST_FWD_ADD;
      ST_FWD_ADD:   state_d = ST_DONE;
      ST_INV_PRIME: state_d = (lvl_i == '0) ? ST_DONE : ST_INV_SCAN;
      ST_INV_SCAN: begin
        if (bracket) begin
          state_d = (den_v == '0) ? ST_DONE : ST_DIV_WAIT;
        end else if (last_seg) begin
          state_d = ST_DONE;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath registers.
  always_comb begin
    x1_d        = x1_q;
    frac_d      = frac_q;
    target_d    = target_q;
    a_d         = a_q;
    prod_d      = prod_q;
    j_d         = j_q;
    seg_d       = seg_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(item_i.entry_index);
    ram_wdata_o = item_i.conductance;
    ram_re_o    = 1'b0;
    ram_raddr_o = x1_q;
    div_start_o = 1'b0;
    div_num_o   = num_v;
    div_den_o   = den_v;
    diff        = $signed({1'b0, ram_rdata_i}) - $signed({1'b0, a_q});
    val         = $signed(PROD_W'({1'b0, a_q})) + (prod_q >>> FRAC_BITS);
    pulse_sum   = PS_W'({seg_v, {FRAC_BITS{1'b0}}});
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        x1_d       = AW'(p_clamp >> FRAC_BITS);
        frac_d     = p_clamp[FRAC_BITS-1:0];
        target_d   = item_i.conductance;
        res_d      = '0;
        if (accept && op == OP_LOAD && {1'b0, item_i.entry_index} <= (IDX_W + 1)'(MAX_LEVEL)) begin
          ram_we_o = 1'b1;
        end
      end
      ST_FWD_RD0: begin
        ram_re_o = 1'b1;
      end
      ST_FWD_RD1: begin
        a_d                      = ram_rdata_i;
        res_d.conductance_result = ram_rdata_i;
        ram_re_o                 = (frac_q != '0);
        ram_raddr_o              = x1_q + 1'b1;
      end
      ST_FWD_MUL: begin
        prod_d = PROD_W'(diff) * $signed({1'b0, frac_q});
      end
      ST_FWD_ADD: begin
        res_d.conductance_result = val[PROD_W-1] ? '0 : val[COND_W-1:0];
      end
      ST_INV_PRIME: begin
        j_d         = '0;
        ram_re_o    = (lvl_i != '0);
        ram_raddr_o = '0;
        res_d.status = (lvl_i == '0);
      end
      ST_INV_SCAN: begin
        ram_raddr_o = j_q + 1'b1;
        if (bracket) begin
          seg_d = seg_v;
          res_d.pulse_result = pulse_sum[PULSE_W-1:0];
          div_start_o = (den_v != '0);
        end else if (last_seg) begin
          res_d.status = 1'b1;
        end else begin
          a_d      = ram_rdata_i;
          j_d      = j_q + 1'b1;
          ram_re_o = 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        pulse_sum = PS_W'({seg_q, {FRAC_BITS{1'b0}}}) + PS_W'(div_quot_i);
        if (div_done_i) begin
          res_d.pulse_result = pulse_sum[PULSE_W-1:0];
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q     <= x1_d;
    frac_q   <= frac_d;
    target_q <= target_d;
    a_q      <= a_d;
    prod_q   <= prod_d;
    j_q      <= j_d;
    seg_q    <= seg_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule
